>>> rtl/qou_pkg.sv
// qou_pkg: shared types, constants, microcode table and helpers for the
// quaternion orientation unit. No dependencies.

package qou_pkg;

   localparam int FracBits = 30;
   localparam logic [63:0] OneVal     = 64'd1 << FracBits;
   localparam logic [63:0] RndConst   = 64'd1 << (FracBits - 1);
   localparam logic [63:0] NearNumer  = 64'd1 << (2 * FracBits + 1);
   localparam logic [63:0] RootNumer  = 64'd1 << (2 * FracBits);
   localparam logic [63:0] SqrtArgMax = 64'hFFFF_FFFF_FFFF_FFFF >> FracBits;

   localparam int ThrW  = 11;
   localparam int IdxW  = 6;
   localparam int AddrW = 3;

   // request commands
   localparam logic [1:0] CmdLoad = 2'd0;
   localparam logic [1:0] CmdMul  = 2'd1;
   localparam logic [1:0] CmdNorm = 2'd2;
   localparam logic [1:0] CmdConj = 2'd3;

   // register index of the threshold
   localparam logic [AddrW-3:0] RegThr = '0;

   // first operand: state component
   localparam logic [1:0] AW = 2'd0;
   localparam logic [1:0] AX = 2'd1;
   localparam logic [1:0] AY = 2'd2;
   localparam logic [1:0] AZ = 2'd3;

   // second operand: request component, state component or scale
   localparam logic [3:0] BIW = 4'd0;
   localparam logic [3:0] BIX = 4'd1;
   localparam logic [3:0] BIY = 4'd2;
   localparam logic [3:0] BIZ = 4'd3;
   localparam logic [3:0] BQW = 4'd4;
   localparam logic [3:0] BQX = 4'd5;
   localparam logic [3:0] BQY = 4'd6;
   localparam logic [3:0] BQZ = 4'd7;
   localparam logic [3:0] BS  = 4'd8;

   // accumulator destinations
   localparam logic [3:0] DT0  = 4'd0;
   localparam logic [3:0] DT1  = 4'd1;
   localparam logic [3:0] DT2  = 4'd2;
   localparam logic [3:0] DT3  = 4'd3;
   localparam logic [3:0] DM2  = 4'd4;
   localparam logic [3:0] DV00 = 4'd5;
   localparam logic [3:0] DV01 = 4'd6;
   localparam logic [3:0] DV02 = 4'd7;
   localparam logic [3:0] DV10 = 4'd8;
   localparam logic [3:0] DV11 = 4'd9;
   localparam logic [3:0] DV12 = 4'd10;
   localparam logic [3:0] DV20 = 4'd11;
   localparam logic [3:0] DV21 = 4'd12;
   localparam logic [3:0] DV22 = 4'd13;

   // microcode segments
   localparam logic [IdxW-1:0] MulBase   = 6'd0;
   localparam logic [IdxW-1:0] MulLast   = 6'd15;
   localparam logic [IdxW-1:0] M2Base    = 6'd16;
   localparam logic [IdxW-1:0] M2Last    = 6'd19;
   localparam logic [IdxW-1:0] ScaleBase = 6'd20;
   localparam logic [IdxW-1:0] ScaleLast = 6'd23;
   localparam logic [IdxW-1:0] VecBase   = 6'd24;
   localparam logic [IdxW-1:0] VecLast   = 6'd41;

   localparam logic [1:0] AxisFwd = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic signed [31:0] in_w;
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
   } req_data_type;

   typedef struct packed {
      logic signed [31:0] q_w;
      logic signed [31:0] q_x;
      logic signed [31:0] q_y;
      logic signed [31:0] q_z;
      logic [1:0]  axis_index;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic        last;
   } rsp_data_type;

   typedef struct packed {
      logic [1:0] a_sel;
      logic [3:0] b_sel;
      logic       neg;
      logic       first;
      logic       fin;
      logic       omin;
      logic [3:0] dst;
   } uop_type;

   typedef struct packed {
      logic            capture;
      logic            load;
      logic            conj;
      logic            prod;
      logic            accum;
      logic            commit;
      logic            sqrt_start;
      logic            div_start;
      logic            div_near;
      logic [IdxW-1:0] idx;
      logic [1:0]      axis;
   } dp_cmd_type;

   typedef struct packed {
      logic m2_zero;
      logic m2_near;
      logic sqrt_busy;
      logic div_busy;
   } dp_stat_type;

   function automatic uop_type ue(logic [1:0] a, logic [3:0] b, logic n, logic f,
                                  logic l, logic o, logic [3:0] d);
      uop_type u;
      u.a_sel = a;
      u.b_sel = b;
      u.neg   = n;
      u.first = f;
      u.fin   = l;
      u.omin  = o;
      u.dst   = d;
      return u;
   endfunction

   // one product term per entry: operands, sign, first/final flags, destination
   function automatic uop_type ucode(logic [IdxW-1:0] idx);
      uop_type u;
      case (idx)
         6'd0:  u = ue(AW, BIW, 1'b0, 1'b1, 1'b0, 1'b0, DT0);
         6'd1:  u = ue(AX, BIX, 1'b1, 1'b0, 1'b0, 1'b0, DT0);
         6'd2:  u = ue(AY, BIY, 1'b1, 1'b0, 1'b0, 1'b0, DT0);
         6'd3:  u = ue(AZ, BIZ, 1'b1, 1'b0, 1'b1, 1'b0, DT0);
         6'd4:  u = ue(AW, BIX, 1'b0, 1'b1, 1'b0, 1'b0, DT1);
         6'd5:  u = ue(AX, BIW, 1'b0, 1'b0, 1'b0, 1'b0, DT1);
         6'd6:  u = ue(AY, BIZ, 1'b1, 1'b0, 1'b0, 1'b0, DT1);
         6'd7:  u = ue(AZ, BIY, 1'b0, 1'b0, 1'b1, 1'b0, DT1);
         6'd8:  u = ue(AW, BIY, 1'b0, 1'b1, 1'b0, 1'b0, DT2);
         6'd9:  u = ue(AX, BIZ, 1'b0, 1'b0, 1'b0, 1'b0, DT2);
         6'd10: u = ue(AY, BIW, 1'b0, 1'b0, 1'b0, 1'b0, DT2);
         6'd11: u = ue(AZ, BIX, 1'b1, 1'b0, 1'b1, 1'b0, DT2);
         6'd12: u = ue(AW, BIZ, 1'b0, 1'b1, 1'b0, 1'b0, DT3);
         6'd13: u = ue(AX, BIY, 1'b1, 1'b0, 1'b0, 1'b0, DT3);
         6'd14: u = ue(AY, BIX, 1'b0, 1'b0, 1'b0, 1'b0, DT3);
         6'd15: u = ue(AZ, BIW, 1'b0, 1'b0, 1'b1, 1'b0, DT3);
         6'd16: u = ue(AW, BQW, 1'b0, 1'b1, 1'b0, 1'b0, DM2);
         6'd17: u = ue(AX, BQX, 1'b0, 1'b0, 1'b0, 1'b0, DM2);
         6'd18: u = ue(AY, BQY, 1'b0, 1'b0, 1'b0, 1'b0, DM2);
         6'd19: u = ue(AZ, BQZ, 1'b0, 1'b0, 1'b1, 1'b0, DM2);
         6'd20: u = ue(AW, BS,  1'b0, 1'b1, 1'b1, 1'b0, DT0);
         6'd21: u = ue(AX, BS,  1'b0, 1'b1, 1'b1, 1'b0, DT1);
         6'd22: u = ue(AY, BS,  1'b0, 1'b1, 1'b1, 1'b0, DT2);
         6'd23: u = ue(AZ, BS,  1'b0, 1'b1, 1'b1, 1'b0, DT3);
         6'd24: u = ue(AY, BQY, 1'b0, 1'b1, 1'b0, 1'b0, DV00);
         6'd25: u = ue(AZ, BQZ, 1'b0, 1'b0, 1'b1, 1'b1, DV00);
         6'd26: u = ue(AX, BQY, 1'b0, 1'b1, 1'b0, 1'b0, DV01);
         6'd27: u = ue(AW, BQZ, 1'b0, 1'b0, 1'b1, 1'b0, DV01);
         6'd28: u = ue(AX, BQZ, 1'b0, 1'b1, 1'b0, 1'b0, DV02);
         6'd29: u = ue(AW, BQY, 1'b1, 1'b0, 1'b1, 1'b0, DV02);
         6'd30: u = ue(AX, BQY, 1'b0, 1'b1, 1'b0, 1'b0, DV10);
         6'd31: u = ue(AW, BQZ, 1'b1, 1'b0, 1'b1, 1'b0, DV10);
         6'd32: u = ue(AX, BQX, 1'b0, 1'b1, 1'b0, 1'b0, DV11);
         6'd33: u = ue(AZ, BQZ, 1'b0, 1'b0, 1'b1, 1'b1, DV11);
         6'd34: u = ue(AY, BQZ, 1'b0, 1'b1, 1'b0, 1'b0, DV12);
         6'd35: u = ue(AW, BQX, 1'b0, 1'b0, 1'b1, 1'b0, DV12);
         6'd36: u = ue(AX, BQZ, 1'b0, 1'b1, 1'b0, 1'b0, DV20);
         6'd37: u = ue(AW, BQY, 1'b0, 1'b0, 1'b1, 1'b0, DV20);
         6'd38: u = ue(AY, BQZ, 1'b0, 1'b1, 1'b0, 1'b0, DV21);
         6'd39: u = ue(AW, BQX, 1'b1, 1'b0, 1'b1, 1'b0, DV21);
         6'd40: u = ue(AX, BQX, 1'b0, 1'b1, 1'b0, 1'b0, DV22);
         6'd41: u = ue(AY, BQY, 1'b0, 1'b0, 1'b1, 1'b1, DV22);
         default: u = '0;
      endcase
      return u;
   endfunction

   function automatic logic [31:0] sat32(logic signed [41:0] v);
      logic [31:0] r;
      if (v > 42'sh0_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -42'sh0_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/qou_ctrl.sv
// qou_ctrl: sequencer for the quaternion orientation unit; walks the
// microcode segments and the sqrt/divide steps. Depends on qou_pkg.

module qou_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_command,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output qou_pkg::dp_cmd_type  cmd,
   input  qou_pkg::dp_stat_type stat
);
   import qou_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_EXEC   = 11'b000_0000_0010,
      S_PROD   = 11'b000_0000_0100,
      S_ACCUM  = 11'b000_0000_1000,
      S_CHECK  = 11'b000_0001_0000,
      S_SQRT   = 11'b000_0010_0000,
      S_SQWAIT = 11'b000_0100_0000,
      S_DIV    = 11'b000_1000_0000,
      S_DVWAIT = 11'b001_0000_0000,
      S_COMMIT = 11'b010_0000_0000,
      S_OUT    = 11'b100_0000_0000
   } state_type;

   state_type       state_ff, state_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [1:0]      cmd_ff, cmd_in;
   logic [1:0]      axis_ff, axis_in;
   logic            near_ff, near_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         cmd_ff   <= CmdLoad;
         axis_ff  <= '0;
         near_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cmd_ff   <= cmd_in;
         axis_ff  <= axis_in;
         near_ff  <= near_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd_in   = cmd_ff;
      axis_in  = axis_ff;
      near_in  = near_ff;
      cmd      = '0;
      cmd.idx  = idx_ff;
      cmd.axis = axis_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               cmd_in = req_command;
               if (req_command == CmdMul) begin
                  idx_in   = MulBase;
                  state_in = S_PROD;
               end else if (req_command == CmdNorm) begin
                  idx_in   = M2Base;
                  state_in = S_PROD;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            cmd.load = (cmd_ff == CmdLoad);
            cmd.conj = (cmd_ff == CmdConj);
            idx_in   = VecBase;
            state_in = S_PROD;
         end
         S_PROD: begin
            cmd.prod = 1'b1;
            state_in = S_ACCUM;
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            if (idx_ff == MulLast || idx_ff == ScaleLast) begin
               state_in = S_COMMIT;
            end else if (idx_ff == M2Last) begin
               state_in = S_CHECK;
            end else if (idx_ff == VecLast) begin
               axis_in  = '0;
               state_in = S_OUT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_PROD;
            end
         end
         S_CHECK: begin
            near_in = stat.m2_near;
            if (stat.m2_zero) begin
               idx_in   = VecBase;
               state_in = S_PROD;
            end else if (stat.m2_near) begin
               state_in = S_DIV;
            end else begin
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.sqrt_start = 1'b1;
            state_in = S_SQWAIT;
         end
         S_SQWAIT: begin
            if (!stat.sqrt_busy) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_near  = near_ff;
            state_in = S_DVWAIT;
         end
         S_DVWAIT: begin
            if (!stat.div_busy) begin
               idx_in   = ScaleBase;
               state_in = S_PROD;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            idx_in   = VecBase;
            state_in = S_PROD;
         end
         S_OUT: begin
            if (rsp_ready) begin
               if (axis_ff == AxisFwd) begin
                  state_in = S_IDLE;
               end else begin
                  axis_in = axis_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/qou_datapath.sv
// qou_datapath: state quaternion, shared multiplier and accumulator, bit-serial
// square root and restoring divider, basis vector registers. Depends on qou_pkg.

module qou_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  qou_pkg::req_data_type req_data,
   input  logic [qou_pkg::ThrW-1:0] thr,
   input  qou_pkg::dp_cmd_type   cmd,
   output qou_pkg::dp_stat_type  stat,
   output qou_pkg::rsp_data_type rsp_data
);
   import qou_pkg::*;

   logic [31:0] q_ff [4];
   logic [31:0] t_ff [4];
   logic [31:0] b_ff [4];
   logic [31:0] v_ff [9];
   logic signed [65:0] prod_ff;
   logic signed [39:0] acc_ff;
   logic [34:0] m2_ff;

   uop_type u;
   logic [31:0] a_word, b_word, s_val;
   logic signed [32:0] a33, b33;
   logic signed [65:0] prod_in, rsum;
   logic signed [35:0] rnd;
   logic signed [36:0] term;
   logic signed [39:0] acc_in;
   logic signed [41:0] fin;
   logic [31:0] fin_sat;
   logic signed [36:0] diff;
   logic [36:0] absd;

   assign u = ucode(cmd.idx);

   always_comb begin
      case (u.a_sel)
         AW: a_word = q_ff[0];
         AX: a_word = q_ff[1];
         AY: a_word = q_ff[2];
         default: a_word = q_ff[3];
      endcase
      case (u.b_sel)
         BIW: b_word = b_ff[0];
         BIX: b_word = b_ff[1];
         BIY: b_word = b_ff[2];
         BIZ: b_word = b_ff[3];
         BQW: b_word = q_ff[0];
         BQX: b_word = q_ff[1];
         BQY: b_word = q_ff[2];
         BQZ: b_word = q_ff[3];
         default: b_word = s_val;
      endcase
      a33 = {a_word[31], a_word};
      b33 = (u.b_sel == BS) ? {1'b0, b_word} : {b_word[31], b_word};
      prod_in = a33 * b33;
   end

   // round to nearest: add half an lsb, floor shift
   always_comb begin
      rsum   = prod_ff + $signed(66'(RndConst));
      rnd    = rsum[FracBits +: 36];
      term   = u.neg ? -{rnd[35], rnd} : {rnd[35], rnd};
      acc_in = u.first ? 40'(term) : acc_ff + 40'(term);
      if (u.dst >= DV00) begin
         fin = u.omin ? $signed(42'(OneVal)) - (42'(acc_in) <<< 1) : (42'(acc_in) <<< 1);
      end else begin
         fin = 42'(acc_in);
      end
      fin_sat = sat32(fin);
   end

   // square root, two argument bits per cycle
   logic [63:0] sq_arg_ff;
   logic [35:0] sq_rem_ff;
   logic [31:0] sq_root_ff;
   logic [4:0]  sq_cnt_ff;
   logic        sq_busy_ff;
   logic [35:0] sq_sh, sq_trial;

   assign sq_sh    = {sq_rem_ff[33:0], sq_arg_ff[63:62]};
   assign sq_trial = {2'b00, sq_root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_busy_ff <= 1'b0;
      end else if (cmd.sqrt_start) begin
         sq_busy_ff <= 1'b1;
      end else if (sq_busy_ff && sq_cnt_ff == '0) begin
         sq_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         sq_arg_ff  <= (64'(m2_ff) > SqrtArgMax) ? '1 : (64'(m2_ff) << FracBits);
         sq_rem_ff  <= '0;
         sq_root_ff <= '0;
         sq_cnt_ff  <= '1;
      end else if (sq_busy_ff) begin
         sq_arg_ff <= {sq_arg_ff[61:0], 2'b00};
         sq_cnt_ff <= sq_cnt_ff - 1'b1;
         if (sq_sh >= sq_trial) begin
            sq_rem_ff  <= sq_sh - sq_trial;
            sq_root_ff <= {sq_root_ff[30:0], 1'b1};
         end else begin
            sq_rem_ff  <= sq_sh;
            sq_root_ff <= {sq_root_ff[30:0], 1'b0};
         end
      end
   end

   // restoring divide, one quotient bit per cycle
   logic [63:0] dv_num_ff, dv_quo_ff;
   logic [35:0] dv_den_ff, dv_rem_ff;
   logic [5:0]  dv_cnt_ff;
   logic        dv_busy_ff;
   logic [36:0] dv_sh;
   logic [35:0] near_den;
   logic [31:0] root1;

   assign dv_sh    = {dv_rem_ff, dv_num_ff[63]};
   assign near_den = 36'(m2_ff) + 36'(OneVal);
   assign root1    = (sq_root_ff == '0) ? 32'd1 : sq_root_ff;
   assign s_val    = (|dv_quo_ff[63:32]) ? 32'hFFFF_FFFF : dv_quo_ff[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         dv_busy_ff <= 1'b1;
      end else if (dv_busy_ff && dv_cnt_ff == '0) begin
         dv_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         if (cmd.div_near) begin
            dv_den_ff <= near_den;
            dv_num_ff <= NearNumer + 64'(near_den >> 1);
         end else begin
            dv_den_ff <= 36'(root1);
            dv_num_ff <= RootNumer + 64'(root1 >> 1);
         end
         dv_rem_ff <= '0;
         dv_quo_ff <= '0;
         dv_cnt_ff <= '1;
      end else if (dv_busy_ff) begin
         dv_num_ff <= {dv_num_ff[62:0], 1'b0};
         dv_cnt_ff <= dv_cnt_ff - 1'b1;
         if (dv_sh >= {1'b0, dv_den_ff}) begin
            dv_rem_ff <= 36'(dv_sh - {1'b0, dv_den_ff});
            dv_quo_ff <= {dv_quo_ff[62:0], 1'b1};
         end else begin
            dv_rem_ff <= dv_sh[35:0];
            dv_quo_ff <= {dv_quo_ff[62:0], 1'b0};
         end
      end
   end

   // state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff[0] <= OneVal[31:0];
         q_ff[1] <= '0;
         q_ff[2] <= '0;
         q_ff[3] <= '0;
      end else if (cmd.load) begin
         q_ff <= b_ff;
      end else if (cmd.conj) begin
         for (int i = 1; i < 4; i++) begin
            q_ff[i] <= sat32(-42'($signed(q_ff[i])));
         end
      end else if (cmd.commit) begin
         q_ff <= t_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         b_ff[0] <= req_data.in_w;
         b_ff[1] <= req_data.in_x;
         b_ff[2] <= req_data.in_y;
         b_ff[3] <= req_data.in_z;
      end
      if (cmd.prod) begin
         prod_ff <= prod_in;
      end
      if (cmd.accum) begin
         acc_ff <= acc_in;
         if (u.fin) begin
            case (u.dst)
               DT0:  t_ff[0] <= fin_sat;
               DT1:  t_ff[1] <= fin_sat;
               DT2:  t_ff[2] <= fin_sat;
               DT3:  t_ff[3] <= fin_sat;
               DM2:  m2_ff   <= acc_in[34:0];
               DV00: v_ff[0] <= fin_sat;
               DV01: v_ff[1] <= fin_sat;
               DV02: v_ff[2] <= fin_sat;
               DV10: v_ff[3] <= fin_sat;
               DV11: v_ff[4] <= fin_sat;
               DV12: v_ff[5] <= fin_sat;
               DV20: v_ff[6] <= fin_sat;
               DV21: v_ff[7] <= fin_sat;
               DV22: v_ff[8] <= fin_sat;
               default: acc_ff <= acc_in;
            endcase
         end
      end
   end

   assign diff = $signed({2'b00, m2_ff}) - $signed(37'(OneVal));
   assign absd = diff[36] ? 37'(-diff) : 37'(diff);

   always_comb begin
      stat.m2_zero   = (m2_ff == '0);
      stat.m2_near   = (absd < 37'(thr));
      stat.sqrt_busy = sq_busy_ff;
      stat.div_busy  = dv_busy_ff;
   end

   always_comb begin
      rsp_data.q_w        = q_ff[0];
      rsp_data.q_x        = q_ff[1];
      rsp_data.q_y        = q_ff[2];
      rsp_data.q_z        = q_ff[3];
      rsp_data.axis_index = cmd.axis;
      rsp_data.last       = (cmd.axis == AxisFwd);
      case (cmd.axis)
         2'd0: begin
            rsp_data.vec_x = v_ff[0];
            rsp_data.vec_y = v_ff[1];
            rsp_data.vec_z = v_ff[2];
         end
         2'd1: begin
            rsp_data.vec_x = v_ff[3];
            rsp_data.vec_y = v_ff[4];
            rsp_data.vec_z = v_ff[5];
         end
         default: begin
            rsp_data.vec_x = v_ff[6];
            rsp_data.vec_y = v_ff[7];
            rsp_data.vec_z = v_ff[8];
         end
      endcase
   end

endmodule

>>> rtl/quaternion_orientation_unit.sv
// Quaternion orientation unit: takes one request at a time (load, multiply,
// normalize, conjugate) and returns three results, right, up and forward,
// each with the updated Q2.30 state. All products go through one shared
// multiplier, one product term after another. Load or conjugate runs the 18
// basis terms and then gives the three result beats; multiply adds 16 terms
// and a commit before them; normalize adds the magnitude terms, the 32-step
// square root, the 64-step restoring divider, the scale terms and a commit.
// A near-unit normalize skips the root, and a zero-magnitude normalize skips
// the root, the divide, the scaling and the commit. Results wait in registers
// for rsp_ready, and a new request is taken once the third result has gone.
// Register 0 at byte address 0 is the near-unit threshold (reset 23).
// Depends on qou_pkg, qou_ctrl, qou_datapath.

module quaternion_orientation_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  qou_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output qou_pkg::rsp_data_type rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [qou_pkg::AddrW-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import qou_pkg::*;

   logic [ThrW-1:0] thr_ff;
   dp_cmd_type      cmd;
   dp_stat_type     stat;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ThrW'(23);
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[AddrW-1:2] == RegThr) begin
         thr_ff <= csr_pwdata[ThrW-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[AddrW-1:2] == RegThr) ? 32'(thr_ff) : '0;

   qou_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_data.command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd),
      .stat        (stat)
   );

   qou_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .thr      (thr_ff),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
